### rtl/sbfr_pkg.sv
// Shared constants and types for the servo bus frame receiver.
// No dependencies; the parser, the result register and the top level use this package.
`timescale 1ns / 1ps

package sbfr_pkg;

   // Default upper bound on the length byte of a frame.
   localparam int MAX_LEN_DEFAULT = 7;

   // Shortest legal length byte: id, length and command only.
   localparam int MIN_LEN = 3;

   // Number of parameter bytes that a result word reports.
   localparam int NUM_PARAMS = 4;

   // Reset value of the header byte register.
   localparam logic [7:0] HEADER_RESET = 8'h55;

   // Byte positions inside a frame, counted from the first header byte.
   localparam int ID_INDEX          = 2;
   localparam int LEN_INDEX         = 3;
   localparam int CMD_INDEX         = 4;
   localparam int FIRST_PARAM_INDEX = 5;

   // Length register value while hunting for a frame.
   localparam int IDLE_LEN = 2;

   // Frame status codes.
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_SUM_ERROR = 1'b1;

   typedef struct packed {
      logic                         frame_status;
      logic [7:0]                   servo_id;
      logic [7:0]                   command_code;
      logic [NUM_PARAMS-1:0][7:0]   params;
      logic [2:0]                   param_count;
   } result_type;

endpackage

### rtl/sbfr_req_if.sv
// Input channel of the servo bus frame receiver: one received byte per word.
// Depends on nothing.
`timescale 1ns / 1ps

interface sbfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/sbfr_rsp_if.sv
// Result channel of the servo bus frame receiver: one word per finished frame.
// Depends on nothing.
`timescale 1ns / 1ps

interface sbfr_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_status;
   logic [7:0] servo_id;
   logic [7:0] command_code;
   logic [7:0] param_0;
   logic [7:0] param_1;
   logic [7:0] param_2;
   logic [7:0] param_3;
   logic [2:0] param_count;

   modport source (output valid, output frame_status, output servo_id,
                   output command_code, output param_0, output param_1,
                   output param_2, output param_3, output param_count,
                   input ready);
   modport sink   (input valid, input frame_status, input servo_id,
                   input command_code, input param_0, input param_1,
                   input param_2, input param_3, input param_count,
                   output ready);
endinterface

### rtl/sbfr_parser.sv
// Frame parser: hunting, header counting, field capture and checksum check.
// Depends on sbfr_pkg for constants and the result word type.
`timescale 1ns / 1ps

module sbfr_parser #(
   parameter int MAX_LEN = sbfr_pkg::MAX_LEN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            header_byte,
   output logic                  res_valid,
   output sbfr_pkg::result_type  res
);

   // The byte index reaches MAX_LEN + 2 at the checksum byte.
   localparam int IDX_W = $clog2(MAX_LEN + 3);
   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int CNT_W = LEN_W + 1;
   localparam int PAR_W = $clog2(sbfr_pkg::NUM_PARAMS);

   logic [1:0]       headers_seen_ff, headers_seen_in;
   logic             in_frame_ff, in_frame_in;
   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [LEN_W-1:0] frame_length_ff, frame_length_in;
   logic [7:0]       running_sum_ff, running_sum_in;
   logic [7:0]       held_id_ff, held_id_in;
   logic [7:0]       held_command_ff, held_command_in;
   logic [7:0]       param_store_ff [sbfr_pkg::NUM_PARAMS];

   logic             param_we;
   logic [IDX_W-1:0] param_slot;
   logic [1:0]       seen_inc;
   logic [CNT_W-1:0] count_full;
   logic [2:0]       count_sat;

   always_comb begin
      headers_seen_in = headers_seen_ff;
      in_frame_in     = in_frame_ff;
      byte_index_in   = byte_index_ff;
      frame_length_in = frame_length_ff;
      running_sum_in  = running_sum_ff;
      held_id_in      = held_id_ff;
      held_command_in = held_command_ff;
      param_we        = 1'b0;
      param_slot      = byte_index_ff - IDX_W'(sbfr_pkg::FIRST_PARAM_INDEX);
      seen_inc        = headers_seen_ff + 2'd1;
      res_valid       = 1'b0;

      count_full = {1'b0, frame_length_ff} - CNT_W'(sbfr_pkg::MIN_LEN);
      if (count_full > CNT_W'(sbfr_pkg::NUM_PARAMS)) begin
         count_sat = 3'(sbfr_pkg::NUM_PARAMS);
      end else begin
         count_sat = 3'(count_full);
      end

      res.servo_id     = held_id_ff;
      res.command_code = held_command_ff;
      res.param_count  = count_sat;
      if (~running_sum_ff == rx_byte) begin
         res.frame_status = sbfr_pkg::STATUS_OK;
      end else begin
         res.frame_status = sbfr_pkg::STATUS_SUM_ERROR;
      end
      // Slots beyond the frame's parameter count read as zero.
      for (int k = 0; k < sbfr_pkg::NUM_PARAMS; k++) begin
         res.params[k] = (3'(k) < count_sat) ? param_store_ff[k] : 8'h00;
      end

      if (step) begin
         if (!in_frame_ff) begin
            if (rx_byte == header_byte) begin
               if (seen_inc >= 2'd2) begin
                  headers_seen_in = 2'd0;
                  in_frame_in     = 1'b1;
                  byte_index_in   = IDX_W'(sbfr_pkg::ID_INDEX);
               end else begin
                  headers_seen_in = seen_inc;
               end
            end else begin
               headers_seen_in = 2'd0;
            end
         end else if (byte_index_ff == IDX_W'(sbfr_pkg::ID_INDEX)) begin
            held_id_in     = rx_byte;
            running_sum_in = rx_byte;
            byte_index_in  = byte_index_ff + IDX_W'(1);
         end else if (byte_index_ff == IDX_W'(sbfr_pkg::LEN_INDEX)) begin
            if (rx_byte < 8'(sbfr_pkg::MIN_LEN) || rx_byte > 8'(MAX_LEN)) begin
               // Bad length: drop the frame and hunt again.
               in_frame_in     = 1'b0;
               headers_seen_in = 2'd0;
               byte_index_in   = '0;
               frame_length_in = LEN_W'(sbfr_pkg::IDLE_LEN);
            end else begin
               frame_length_in = LEN_W'(rx_byte);
               running_sum_in  = running_sum_ff + rx_byte;
               byte_index_in   = byte_index_ff + IDX_W'(1);
            end
         end else if (byte_index_ff == IDX_W'(sbfr_pkg::CMD_INDEX)) begin
            held_command_in = rx_byte;
            running_sum_in  = running_sum_ff + rx_byte;
            byte_index_in   = byte_index_ff + IDX_W'(1);
         end else if (byte_index_ff <
                      IDX_W'(frame_length_ff) + IDX_W'(sbfr_pkg::ID_INDEX)) begin
            // Parameters past the stored slots only enter the sum.
            param_we       = (param_slot < IDX_W'(sbfr_pkg::NUM_PARAMS));
            running_sum_in = running_sum_ff + rx_byte;
            byte_index_in  = byte_index_ff + IDX_W'(1);
         end else begin
            // Checksum byte: report the frame and hunt again.
            res_valid       = 1'b1;
            in_frame_in     = 1'b0;
            headers_seen_in = 2'd0;
            byte_index_in   = '0;
            frame_length_in = LEN_W'(sbfr_pkg::IDLE_LEN);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         headers_seen_ff <= 2'd0;
         in_frame_ff     <= 1'b0;
         byte_index_ff   <= '0;
         frame_length_ff <= LEN_W'(sbfr_pkg::IDLE_LEN);
         running_sum_ff  <= 8'h00;
      end else begin
         headers_seen_ff <= headers_seen_in;
         in_frame_ff     <= in_frame_in;
         byte_index_ff   <= byte_index_in;
         frame_length_ff <= frame_length_in;
         running_sum_ff  <= running_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      held_id_ff      <= held_id_in;
      held_command_ff <= held_command_in;
      if (param_we) begin
         param_store_ff[param_slot[PAR_W-1:0]] <= rx_byte;
      end
   end

endmodule

### rtl/sbfr_out_reg.sv
// Result register: holds one result word until the sink takes it.
// Depends on sbfr_pkg for the result word type.
`timescale 1ns / 1ps

module sbfr_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  sbfr_pkg::result_type  load_data,
   input  logic                  out_ready,
   output logic                  out_valid,
   output sbfr_pkg::result_type  out_data,
   output logic                  busy
);

   logic                 valid_ff, valid_in;
   sbfr_pkg::result_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   // The register can take a new word when empty or emptied this cycle.
   assign busy      = valid_ff && !out_ready;

endmodule

### rtl/servo_bus_frame_receiver.sv
// Top level of the servo bus frame receiver: header register, input stage,
// parser and result register. Depends on sbfr_pkg, sbfr_req_if, sbfr_rsp_if,
// sbfr_parser and sbfr_out_reg.
`timescale 1ns / 1ps

// The receiver takes serial bytes, one per word on the req channel, and
// looks for two consecutive bytes equal to the header register (0x55 after
// reset, changed through csr_wr_en / csr_wr_data; the user must do so only
// while the block is idle, as the block itself does not enforce it). After
// the headers come an id byte, a length byte, a command byte, length - 3
// parameter bytes and a checksum byte. A length below 3 or above MAX_LEN
// drops the frame without a result and hunting starts again. At the checksum
// byte one word goes out on the rsp channel: frame_status is 0 when the
// received byte equals the inverted low byte of the sum from the id byte
// through the last parameter, and 1 otherwise. The first four parameters are
// reported, unused slots read as zero, and param_count gives how many are
// valid. The block accepts one byte word every clock cycle while the rsp side
// keeps up, as the parser's state update is combinational. A byte is
// registered in the input register on acceptance and parsed from there;
// the result register loads the word when its checksum byte is parsed.
// While a result word waits unaccepted in the result register, the parser
// holds; the req side then takes at most one more byte into the input
// register and stalls. Both resume in the cycle the waiting word is taken.

module servo_bus_frame_receiver #(
   parameter int MAX_LEN = sbfr_pkg::MAX_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   sbfr_req_if.sink    req_chan,
   sbfr_rsp_if.source  rsp_chan
);

   logic [7:0] header_byte_ff, header_byte_in;

   // Input stage.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   logic                 step;
   logic                 out_busy;
   logic                 res_valid;
   sbfr_pkg::result_type res;
   sbfr_pkg::result_type rsp_data;

   // The user must write the header only with no frame in flight; not enforced.
   assign header_byte_in = csr_wr_en ? csr_wr_data : header_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff <= sbfr_pkg::HEADER_RESET;
      end else begin
         header_byte_ff <= header_byte_in;
      end
   end

   // The parser consumes the held byte unless a finished word is still
   // waiting in the result register.
   assign step           = in_valid_ff && !out_busy;
   assign req_chan.ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_byte_in  = req_chan.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   sbfr_parser #(
      .MAX_LEN (MAX_LEN)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_byte     (in_byte_ff),
      .header_byte (header_byte_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   sbfr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_data  (rsp_data),
      .busy      (out_busy)
   );

   assign rsp_chan.frame_status = rsp_data.frame_status;
   assign rsp_chan.servo_id     = rsp_data.servo_id;
   assign rsp_chan.command_code = rsp_data.command_code;
   assign rsp_chan.param_0      = rsp_data.params[0];
   assign rsp_chan.param_1      = rsp_data.params[1];
   assign rsp_chan.param_2      = rsp_data.params[2];
   assign rsp_chan.param_3      = rsp_data.params[3];
   assign rsp_chan.param_count  = rsp_data.param_count;

endmodule
